// File: sv/m2q_pkg.sv
// Shared types and constants for the matrix to quaternion converter.
// No dependencies; imported by every module of the block.
`default_nettype none
package m2q_pkg;

    // Width of the signed sum or difference of two matrix elements.
    localparam int SUM_W = 17;

    // Which quaternion component is taken straight from the square root.
    localparam logic [1:0] LEAD_W = 2'd0;
    localparam logic [1:0] LEAD_X = 2'd1;
    localparam logic [1:0] LEAD_Y = 2'd2;
    localparam logic [1:0] LEAD_Z = 2'd3;

    // Per-transaction data that travels alongside the arithmetic cells.
    typedef struct packed {
        logic                       vld;
        logic                       degen;
        logic [1:0]                 lead;
        logic [3:0][SUM_W-1:0]      sums;   // w, x, y, z numerators
    } side_t;

endpackage
`default_nettype wire

// File: sv/matrix_to_quaternion.sv
// Rotation matrix to quaternion converter (Shepperd's method), signed fixed point.
// Pipeline: one root cell per root bit, then one divider cell per quotient bit,
// then the output register.
// Throughput is one transaction per cycle; the whole pipe halts while a result waits
// with m_ready low.
// Reset (aresetn, synchronous, active low) clears all valid flags; no data is reset.
`default_nettype none
module matrix_to_quaternion
    import m2q_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_m00,
    input  wire logic [15:0] s_m01,
    input  wire logic [15:0] s_m02,
    input  wire logic [15:0] s_m10,
    input  wire logic [15:0] s_m11,
    input  wire logic [15:0] s_m12,
    input  wire logic [15:0] s_m20,
    input  wire logic [15:0] s_m21,
    input  wire logic [15:0] s_m22,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_quat_w,
    output logic [15:0]      m_quat_x,
    output logic [15:0]      m_quat_y,
    output logic [15:0]      m_quat_z,
    output logic             m_degenerate
);
    // The root argument is below 2^17 + 2^FRAC_BITS, so it fits ARG_W unsigned bits.
    localparam int ARG_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int CW    = ARG_W + 1;
    localparam int RAD_W = ARG_W + FRAC_BITS;
    localparam int RW    = (RAD_W + 1) / 2;
    localparam int DW    = RW + 1;
    localparam int NQ    = SUM_W + FRAC_BITS;
    localparam int HW    = RW - 1;
    localparam int EXT   = (HW > 17) ? HW : 17;

    localparam logic signed [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

    // The whole chain advances together whenever the output register can move.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // Front end: trace, branch choice, root argument and the numerators.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] e00, e11, e22, trace_v, arg_v;
    logic signed [SUM_W-1:0] d12, d20, d01, p10, p02, p21;
    logic        m11_gt;
    logic        m22_gt;
    logic [1:0]  lead_v;
    side_t       front_side;
    logic [2*RW-1:0] front_rad;

    always_comb begin
        e00     = CW'($signed(s_m00));
        e11     = CW'($signed(s_m11));
        e22     = CW'($signed(s_m22));
        trace_v = e00 + e11 + e22;

        d12 = SUM_W'($signed(s_m12)) - SUM_W'($signed(s_m21));
        d20 = SUM_W'($signed(s_m20)) - SUM_W'($signed(s_m02));
        d01 = SUM_W'($signed(s_m01)) - SUM_W'($signed(s_m10));
        p10 = SUM_W'($signed(s_m10)) + SUM_W'($signed(s_m01));
        p02 = SUM_W'($signed(s_m02)) + SUM_W'($signed(s_m20));
        p21 = SUM_W'($signed(s_m21)) + SUM_W'($signed(s_m12));

        // Largest diagonal element, ties going to the lower axis.
        m11_gt = ($signed(s_m11) > $signed(s_m00));
        if (m11_gt) begin
            m22_gt = ($signed(s_m22) > $signed(s_m11));
        end else begin
            m22_gt = ($signed(s_m22) > $signed(s_m00));
        end

        if (trace_v > 0) begin
            lead_v = LEAD_W;
        end else if (m22_gt) begin
            lead_v = LEAD_Z;
        end else if (m11_gt) begin
            lead_v = LEAD_Y;
        end else begin
            lead_v = LEAD_X;
        end

        front_side      = '0;
        front_side.vld  = s_valid;
        front_side.lead = lead_v;
        case (lead_v)
            LEAD_W: begin
                arg_v = trace_v + ONE_C;
                front_side.sums = {d01, d20, d12, SUM_W'(0)};
            end
            LEAD_X: begin
                arg_v = e00 - e11 - e22 + ONE_C;
                front_side.sums = {p02, p10, SUM_W'(0), d12};
            end
            LEAD_Y: begin
                arg_v = e11 - e22 - e00 + ONE_C;
                front_side.sums = {p21, SUM_W'(0), p10, d20};
            end
            default: begin
                arg_v = e22 - e00 - e11 + ONE_C;
                front_side.sums = {SUM_W'(0), p21, p02, d01};
            end
        endcase
        front_side.degen = (arg_v <= 0);
        front_rad = (2*RW)'({arg_v[ARG_W-1:0], {FRAC_BITS{1'b0}}});
    end

    // ------------------------------------------------------------------
    // Square root chain: RW cells, one root bit each.
    // ------------------------------------------------------------------
    logic [RW:0]     sq_rem  [RW+1];
    logic [RW-1:0]   sq_root [RW+1];
    logic [2*RW-1:0] sq_rad  [RW+1];
    side_t           sq_side [RW+1];

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = front_rad;
    assign sq_side[0] = front_side;

    for (genvar gi = 0; gi < RW; gi++) begin : g_sqrt
        side_t side_reg;

        m2q_sqrt_cell #(.RW(RW)) u_cell (
            .aclk     (aclk),
            .en       (en),
            .rem_in   (sq_rem[gi]),
            .root_in  (sq_root[gi]),
            .rad_in   (sq_rad[gi]),
            .rem_out  (sq_rem[gi+1]),
            .root_out (sq_root[gi+1]),
            .rad_out  (sq_rad[gi+1])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg.vld <= 1'b0;
            end else if (en) begin
                side_reg <= sq_side[gi];
            end
        end
        assign sq_side[gi+1] = side_reg;
    end

    // ------------------------------------------------------------------
    // Divider chain: four lanes (w, x, y, z) of NQ cells each, dividing
    // |numerator| << FRAC_BITS by twice the root.
    // ------------------------------------------------------------------
    logic [DW-1:0] dv_dvs [4][NQ+1];
    logic [DW-1:0] dv_rem [4][NQ+1];
    logic [NQ-1:0] dv_dq  [4][NQ+1];
    side_t         dv_side [NQ+1];
    logic [HW-1:0] dv_half [NQ+1];

    assign dv_side[0] = sq_side[RW];
    assign dv_half[0] = sq_root[RW][RW-1:1];

    for (genvar gl = 0; gl < 4; gl++) begin : g_lane
        logic [SUM_W-1:0] num;
        logic [SUM_W-1:0] mag;

        assign num = sq_side[RW].sums[gl];
        assign mag = num[SUM_W-1] ? (SUM_W'(0) - num) : num;
        assign dv_dvs[gl][0] = {sq_root[RW], 1'b0};
        assign dv_rem[gl][0] = '0;
        assign dv_dq[gl][0]  = {mag, {FRAC_BITS{1'b0}}};

        for (genvar gk = 0; gk < NQ; gk++) begin : g_cell
            m2q_div_cell #(.DW(DW), .NQ(NQ)) u_cell (
                .aclk    (aclk),
                .en      (en),
                .dvs_in  (dv_dvs[gl][gk]),
                .rem_in  (dv_rem[gl][gk]),
                .dq_in   (dv_dq[gl][gk]),
                .dvs_out (dv_dvs[gl][gk+1]),
                .rem_out (dv_rem[gl][gk+1]),
                .dq_out  (dv_dq[gl][gk+1])
            );
        end
    end

    for (genvar gk = 0; gk < NQ; gk++) begin : g_dside
        side_t         side_reg;
        logic [HW-1:0] half_reg;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg.vld <= 1'b0;
            end else if (en) begin
                side_reg <= dv_side[gk];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                half_reg <= dv_half[gk];
            end
        end
        assign dv_side[gk+1] = side_reg;
        assign dv_half[gk+1] = half_reg;
    end

    // ------------------------------------------------------------------
    // Output stage: sign, saturation, lead component and degenerate case.
    // ------------------------------------------------------------------
    side_t         fin;
    logic [EXT-1:0] half_ext;
    logic [15:0]   lead_val;
    logic [15:0]   comp [4];

    assign fin      = dv_side[NQ];
    assign half_ext = EXT'(dv_half[NQ]);
    assign lead_val = (half_ext > EXT'(32767)) ? 16'h7FFF : half_ext[15:0];

    for (genvar gl = 0; gl < 4; gl++) begin : g_sat
        logic [NQ-1:0] quo;
        logic [NQ-1:0] neg_quo;
        logic          neg;

        assign quo     = dv_dq[gl][NQ];
        assign neg_quo = NQ'(0) - quo;
        assign neg     = fin.sums[gl][SUM_W-1];

        always_comb begin
            if (fin.degen) begin
                comp[gl] = 16'h0000;
            end else if (fin.lead == 2'(gl)) begin
                comp[gl] = lead_val;
            end else if (neg) begin
                comp[gl] = (quo > NQ'(32768)) ? 16'h8000 : neg_quo[15:0];
            end else begin
                comp[gl] = (quo > NQ'(32767)) ? 16'h7FFF : quo[15:0];
            end
        end
    end

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= fin.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_quat_w     <= comp[0];
            m_quat_x     <= comp[1];
            m_quat_y     <= comp[2];
            m_quat_z     <= comp[3];
            m_degenerate <= fin.degen;
        end
    end

    assign m_valid = m_valid_reg;
endmodule
`default_nettype wire

// File: sv/m2q_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cycle while en is high.
// Depends on m2q_pkg.
`default_nettype none
module m2q_sqrt_cell
    import m2q_pkg::*;
#(
    parameter int RW = 13
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [RW:0]     rem_in,
    input  wire logic [RW-1:0]   root_in,
    input  wire logic [2*RW-1:0] rad_in,
    output logic [RW:0]          rem_out,
    output logic [RW-1:0]        root_out,
    output logic [2*RW-1:0]      rad_out
);
    logic [RW:0]     rem_reg;
    logic [RW-1:0]   root_reg;
    logic [2*RW-1:0] rad_reg;
    logic [RW+2:0]   trial_val;
    logic [RW+2:0]   probe;
    logic            fits;
    logic [RW+2:0]   diff;

    always_comb begin
        trial_val = {rem_in, rad_in[2*RW-1 -: 2]};
        probe     = {1'b0, root_in, 2'b01};
        fits      = (trial_val >= probe);
        diff      = fits ? (trial_val - probe) : trial_val;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= diff[RW:0];
            root_reg <= {root_in[RW-2:0], fits};
            rad_reg  <= {rad_in[2*RW-3:0], 2'b00};
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;
endmodule
`default_nettype wire

// File: sv/m2q_div_cell.sv
// One cell of a restoring divider chain: settles one quotient bit per cycle while en is high.
// Depends on m2q_pkg.
`default_nettype none
module m2q_div_cell
    import m2q_pkg::*;
#(
    parameter int DW = 14,
    parameter int NQ = 31
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [DW-1:0] dvs_in,
    input  wire logic [DW-1:0] rem_in,
    input  wire logic [NQ-1:0] dq_in,
    output logic [DW-1:0]      dvs_out,
    output logic [DW-1:0]      rem_out,
    output logic [NQ-1:0]      dq_out
);
    logic [DW-1:0] dvs_reg;
    logic [DW-1:0] rem_reg;
    logic [NQ-1:0] dq_reg;
    logic [DW:0]   part;
    logic          fits;
    logic [DW:0]   diff;

    always_comb begin
        part = {rem_in, dq_in[NQ-1]};
        fits = (part >= {1'b0, dvs_in});
        diff = fits ? (part - {1'b0, dvs_in}) : part;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dvs_reg <= dvs_in;
            rem_reg <= diff[DW-1:0];
            dq_reg  <= {dq_in[NQ-2:0], fits};
        end
    end

    assign dvs_out = dvs_reg;
    assign rem_out = rem_reg;
    assign dq_out  = dq_reg;
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for matrix_to_quaternion: random and directed rotation matrices.
// Needs the RTL of the block and its package m2q_pkg; reads no files.

class quat_scoreboard;
    typedef struct {
        logic [15:0] w, x, y, z;
        logic        degen;
    } quat_t;

    quat_t pending[$];
    int    errors;
    int    checked;
    int    degen_seen;

    // Floor of the integer square root.
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd3037000499;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // Fixed-point quotient num / den2, truncated toward zero.
    function automatic longint quot(longint num, longint den2);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag <<< 14) / den2;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic logic [15:0] clip(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // Works out the quaternion for one matrix and queues it.
    function void note_matrix(logic signed [15:0] m [3][3]);
        longint e [3][3];
        longint q [3];
        longint w, tr, arg, r;
        int i, j, k;
        quat_t res;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                e[a][b] = m[a][b];
        tr = e[0][0] + e[1][1] + e[2][2];
        res.degen = 1'b0;
        if (tr > 0) begin
            arg = tr + (64'sd1 <<< 14);
            r = isqrt(arg << 14);
            w = r >>> 1;
            q[0] = quot(e[1][2] - e[2][1], 2 * r);
            q[1] = quot(e[2][0] - e[0][2], 2 * r);
            q[2] = quot(e[0][1] - e[1][0], 2 * r);
        end else begin
            i = 0;
            if (e[1][1] > e[0][0]) i = 1;
            if (e[2][2] > e[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            arg = e[i][i] - e[j][j] - e[k][k] + (64'sd1 <<< 14);
            if (arg <= 0) begin
                res.degen = 1'b1;
                w = 0; q[0] = 0; q[1] = 0; q[2] = 0;
            end else begin
                r = isqrt(arg << 14);
                q[i] = r >>> 1;
                w = quot(e[j][k] - e[k][j], 2 * r);
                q[j] = quot(e[j][i] + e[i][j], 2 * r);
                q[k] = quot(e[i][k] + e[k][i], 2 * r);
            end
        end
        res.w = clip(w);
        res.x = clip(q[0]);
        res.y = clip(q[1]);
        res.z = clip(q[2]);
        pending.push_back(res);
    endfunction

    function void check_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, logic degen);
        quat_t exp_q;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result w=%h x=%h y=%h z=%h degenerate=%b",
                     $time, w, x, y, z, degen);
            errors++;
            return;
        end
        exp_q = pending.pop_front();
        checked++;
        if (exp_q.degen) degen_seen++;
        if (w !== exp_q.w) begin
            $display("%0t: quat_w expected %h actual %h", $time, exp_q.w, w);
            errors++;
        end
        if (x !== exp_q.x) begin
            $display("%0t: quat_x expected %h actual %h", $time, exp_q.x, x);
            errors++;
        end
        if (y !== exp_q.y) begin
            $display("%0t: quat_y expected %h actual %h", $time, exp_q.y, y);
            errors++;
        end
        if (z !== exp_q.z) begin
            $display("%0t: quat_z expected %h actual %h", $time, exp_q.z, z);
            errors++;
        end
        if (degen !== exp_q.degen) begin
            $display("%0t: degenerate expected %b actual %b", $time, exp_q.degen, degen);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import m2q_pkg::*;

    localparam int ONE = 1 << 14;
    // Pipeline depth of the block, plus margin for the drain.
    localparam int DRAIN_CYCLES = 120;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_m00, s_m01, s_m02, s_m10, s_m11, s_m12, s_m20, s_m21, s_m22;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_quat_w, m_quat_x, m_quat_y, m_quat_z;
    logic        m_degenerate;

    quat_scoreboard quat_board;
    bit             stim_done;
    int             sent;

    matrix_to_quaternion u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_m00(s_m00), .s_m01(s_m01), .s_m02(s_m02),
        .s_m10(s_m10), .s_m11(s_m11), .s_m12(s_m12),
        .s_m20(s_m20), .s_m21(s_m21), .s_m22(s_m22),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_quat_w(m_quat_w), .m_quat_x(m_quat_x),
        .m_quat_y(m_quat_y), .m_quat_z(m_quat_z),
        .m_degenerate(m_degenerate)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Idle lengths: most often none, else short, now and then a long stretch.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Presents one matrix and holds it until the block takes the transaction.
    // The expectation is noted at the accepting edge, from the held payload.
    // With no gap after it, valid stays high into the next transaction, so the
    // caller drops valid itself before it pauses.
    task automatic send_matrix(logic signed [15:0] m [3][3]);
        int gap;
        s_m00 <= m[0][0]; s_m01 <= m[0][1]; s_m02 <= m[0][2];
        s_m10 <= m[1][0]; s_m11 <= m[1][1]; s_m12 <= m[1][2];
        s_m20 <= m[2][0]; s_m21 <= m[2][1]; s_m22 <= m[2][2];
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        quat_board.note_matrix(m);
        sent++;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Random element: mostly within the rotation range [-1, 1], sometimes any code.
    function automatic logic [15:0] rand_elem();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 2 * ONE) - ONE);
    endfunction

    // Draws a random matrix; for most draws one chosen diagonal axis is made
    // dominant, so that every branch sees plenty of traffic.
    task automatic random_matrix(output logic signed [15:0] m [3][3]);
        int lead;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                m[a][b] = rand_elem();
        lead = $urandom_range(0, 4);
        if (lead < 3) begin
            m[lead][lead] = 16'($urandom_range(0, ONE));
            for (int a = 0; a < 3; a++)
                if (a != lead) m[a][a] = 16'(-int'($urandom_range(0, ONE)));
        end
    endtask

    task automatic fill(output logic signed [15:0] m [3][3],
                        input int d0, int d1, int d2, int off);
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                m[a][b] = 16'(off);
        m[0][0] = 16'(d0); m[1][1] = 16'(d1); m[2][2] = 16'(d2);
    endtask

    // Sender: directed corner matrices first, then the random stream.
    initial begin
        logic signed [15:0] m [3][3];
        s_valid = 1'b0;
        {s_m00, s_m01, s_m02, s_m10, s_m11, s_m12, s_m20, s_m21, s_m22} = '0;
        aresetn = 1'b0;
        stim_done = 1'b0;
        sent = 0;
        quat_board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Identity and half-turns about each axis (each lead component).
        fill(m, ONE, ONE, ONE, 0);              send_matrix(m);
        fill(m, ONE, -ONE, -ONE, 0);            send_matrix(m);
        fill(m, -ONE, ONE, -ONE, 0);            send_matrix(m);
        fill(m, -ONE, -ONE, ONE, 0);            send_matrix(m);
        // Ties on the diagonal go to the lower index.
        fill(m, 0, 0, -ONE, 100);               send_matrix(m);
        fill(m, -ONE, 0, 0, -100);              send_matrix(m);
        fill(m, -ONE, -ONE, -ONE, 5);           send_matrix(m);
        // Extreme diagonals that push the root argument to its limits.
        fill(m, 0, 0, ONE, 0);                  send_matrix(m);
        fill(m, -32768, -32768, -32768, 0);     send_matrix(m);
        fill(m, 0, 32767, 32767, 7);            send_matrix(m);
        // Trace exactly zero takes the diagonal branch; trace one takes the other.
        fill(m, 0, 0, 0, 1234);                 send_matrix(m);
        fill(m, 1, 0, 0, -1234);                send_matrix(m);
        // Extreme codes that drive the quotients into saturation.
        fill(m, 32767, 32767, 32767, 32767);    send_matrix(m);
        fill(m, 32767, -32768, -32768, -32768); send_matrix(m);
        fill(m, -32768, 32767, -32768, 32767);  send_matrix(m);
        fill(m, 1, -32768, -32768, 0);
        m[0][1] = 32767; m[1][0] = -32768; m[2][1] = -32768; m[1][2] = 32767;
        send_matrix(m);
        fill(m, -32768, -32768, 32767, -1);     send_matrix(m);

        // Hold off until the pipe is empty, then resume.
        s_valid <= 1'b0;
        while (quat_board.pending.size() != 0) @(posedge aclk);

        for (int n = 0; n < 2000; n++) begin
            random_matrix(m);
            send_matrix(m);
            if (n == 1000) begin
                s_valid <= 1'b0;
                while (quat_board.pending.size() != 0) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random back-pressure, results checked at the accepting edge.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = gap_len();
            if (stall == 0) begin
                m_ready <= 1'b1;
                @(posedge aclk);
                if (m_valid && m_ready)
                    quat_board.check_quat(m_quat_w, m_quat_x, m_quat_y,
                                          m_quat_z, m_degenerate);
            end else begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Normal end: everything sent, everything checked, then a quiet drain period
    // so any stray extra result would still be caught.
    initial begin
        wait (stim_done);
        while (quat_board.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d matrices, %0d results checked, %0d degenerate.",
                 sent, quat_board.checked, quat_board.degen_seen);
        if (quat_board.errors == 0 && quat_board.pending.size() == 0)
            $display("matrix_to_quaternion regression: pass");
        else
            $display("matrix_to_quaternion regression: fail");
        $finish;
    end

    // Watchdog: set far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding.", quat_board.pending.size());
        $display("matrix_to_quaternion regression: fail");
        $finish;
    end
endmodule

// File: matrix_to_quaternion.f
sv/m2q_pkg.sv
sv/m2q_sqrt_cell.sv
sv/m2q_div_cell.sv
sv/matrix_to_quaternion.sv
bench/tb_top.sv
